### src/mbe_pkg.sv
// shared constants and types for the mandelbrot escape-time block
// no dependencies; used by the top level and its checker
package mbe_pkg;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int COUNT_W = 16;

  // width of one operand limb of the shared multiplier
  localparam int LIMB_W = 32;

  // iteration limit after reset
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

  // which product the shared multiplier is forming
  typedef enum logic [1:0] {
    OP_XY,
    OP_XX,
    OP_YY
  } op_t;

endpackage

### src/mandelbrot_escape_time.sv
// mandelbrot escape-time counter with one shared 32x32 multiplier
// depends on mbe_pkg
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   c_re, c_im
//   out      output     out_valid / out_stall escape_count, stayed_inside
//   cfg      input      cfg_write_en          cfg_write_data (max_iterations)
//
// one word at a time; in_stall stays high from acceptance until the result is
// moved into the output register. each iteration forms three wide products
// (x*y, x'*x', y'*y') limb by limb on the one 32x32 multiplier, a multiply
// state and an accumulate state per partial product, plus update, magnitude
// and escape-test states (NL = 1 limb per operand at FRAC_BITS up to 29, else 2);
// entry and hand-off go through the idle and done states.
// reset is synchronous and clears the sequencer, the output valid flag and
// the limit (back to 256). a stalled result holds in the output register
// while the next word is accepted.
module mandelbrot_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           c_re,
  input  logic signed [31:0]           c_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  escape_count,
  output logic                         stayed_inside,
  input  logic                         cfg_write_en,
  input  logic [15:0]                  cfg_write_data
);

  localparam int LW  = mbe_pkg::LIMB_W;
  localparam int CW  = mbe_pkg::COUNT_W;
  // signed width of a z part after an update, magnitude width
  localparam int ZW  = ((FRAC_BITS > 29) ? FRAC_BITS : 29) + 4;
  localparam int MW  = ZW - 1;
  // limbs per operand, padded operand width, full product width
  localparam int NL  = (MW + LW - 1) / LW;
  localparam int OPW = NL * LW;
  localparam int PW  = 2 * OPW;
  // partial product counter and shift amount widths
  localparam int PCW = $clog2(NL * NL) + 1;
  localparam int SHW = $clog2(PW) + 1;
  // escape threshold 4 * 2^(2*FRAC_BITS)
  localparam logic [PW:0] LIMIT = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_UPD,
    S_MAG,
    S_CHK,
    S_DONE
  } state_t;

  state_t           state;
  mbe_pkg::op_t     op;
  logic [PCW-1:0]   pp;
  logic [CW-1:0]    max_iterations;
  logic [CW-1:0]    p;
  logic signed [31:0] cre, cim;
  logic signed [ZW-1:0] x, y;
  logic [MW-1:0]    xm, ym;
  logic [PW-1:0]    xx, yy, xy, acc;
  logic [2*LW-1:0]  prod;
  logic [CW-1:0]    res_count;
  logic             res_inside;

  // limb selection for the current partial product
  logic [PCW-1:0]   i_idx, j_idx;
  logic [OPW-1:0]   opa, opb;
  logic [LW-1:0]    limb_a, limb_b;
  logic [SHW-1:0]   sh_a, sh_b, sh_acc;
  logic             last_pp;

  always_comb begin
    i_idx   = PCW'(pp / NL);
    j_idx   = PCW'(pp % NL);
    sh_a    = SHW'(i_idx * LW);
    sh_b    = SHW'(j_idx * LW);
    sh_acc  = SHW'((i_idx + j_idx) * LW);
    last_pp = (pp == PCW'(NL * NL - 1));
    case (op)
      mbe_pkg::OP_XY: begin
        opa = OPW'(xm);
        opb = OPW'(ym);
      end
      mbe_pkg::OP_XX: begin
        opa = OPW'(xm);
        opb = OPW'(xm);
      end
      mbe_pkg::OP_YY: begin
        opa = OPW'(ym);
        opb = OPW'(ym);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    limb_a = LW'(opa >> sh_a);
    limb_b = LW'(opb >> sh_b);
  end

  // z update: re' = floor((xx - yy) / 2^F) + c_re, im' = floor(2xy / 2^F) + c_im
  logic signed [PW:0]   diff, xy_s;
  logic signed [PW+1:0] xy2;
  logic signed [PW:0]   diff_sh;
  logic signed [PW+1:0] xy2_sh;
  logic signed [ZW-1:0] x_upd, y_upd;
  logic                 xy_neg;

  always_comb begin
    xy_neg  = x[ZW-1] ^ y[ZW-1];
    diff    = $signed({1'b0, xx}) - $signed({1'b0, yy});
    xy_s    = xy_neg ? -$signed({1'b0, xy}) : $signed({1'b0, xy});
    xy2     = {xy_s, 1'b0};
    diff_sh = diff >>> FRAC_BITS;
    xy2_sh  = xy2 >>> FRAC_BITS;
    x_upd   = ZW'(diff_sh) + ZW'(cre);
    y_upd   = ZW'(xy2_sh) + ZW'(cim);
  end

  // escape test and iteration end
  logic [PW:0] mag_sq;
  logic        escaped;
  logic        last_iter;

  always_comb begin
    mag_sq    = {1'b0, xx} + {1'b0, yy};
    escaped   = (mag_sq > LIMIT);
    last_iter = (({1'b0, p} + (CW + 1)'(1)) == {1'b0, max_iterations});
  end

  assign in_stall = (state != S_IDLE);

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      max_iterations <= mbe_pkg::MAX_ITER_RESET;
      op             <= mbe_pkg::OP_XY;
      pp             <= '0;
    end else begin
      if (cfg_write_en) begin
        max_iterations <= cfg_write_data;
      end
      // output word loads from the sequencer or leaves on acceptance
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cre <= c_re;
            cim <= c_im;
            x   <= '0;
            y   <= '0;
            xm  <= '0;
            ym  <= '0;
            xx  <= '0;
            yy  <= '0;
            p   <= '0;
            acc <= '0;
            pp  <= '0;
            op  <= mbe_pkg::OP_XY;
            if (max_iterations == '0) begin
              res_count  <= '0;
              res_inside <= 1'b1;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= limb_a * limb_b;
          state <= S_ACC;
        end
        S_ACC: begin
          if (last_pp) begin
            pp  <= '0;
            acc <= '0;
            case (op)
              mbe_pkg::OP_XY: begin
                xy    <= acc + (PW'(prod) << sh_acc);
                state <= S_UPD;
              end
              mbe_pkg::OP_XX: begin
                xx    <= acc + (PW'(prod) << sh_acc);
                op    <= mbe_pkg::OP_YY;
                state <= S_MUL;
              end
              default: begin
                yy    <= acc + (PW'(prod) << sh_acc);
                state <= S_CHK;
              end
            endcase
          end else begin
            acc   <= acc + (PW'(prod) << sh_acc);
            pp    <= pp + PCW'(1);
            state <= S_MUL;
          end
        end
        S_UPD: begin
          x     <= x_upd;
          y     <= y_upd;
          state <= S_MAG;
        end
        S_MAG: begin
          xm    <= MW'(x[ZW-1] ? -x : x);
          ym    <= MW'(y[ZW-1] ? -y : y);
          op    <= mbe_pkg::OP_XX;
          state <= S_MUL;
        end
        S_CHK: begin
          if (escaped) begin
            res_count  <= p;
            res_inside <= 1'b0;
            state      <= S_DONE;
          end else if (last_iter) begin
            res_count  <= max_iterations;
            res_inside <= 1'b1;
            state      <= S_DONE;
          end else begin
            p     <= p + CW'(1);
            op    <= mbe_pkg::OP_XY;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            escape_count  <= res_count;
            stayed_inside <= res_inside;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/mbe_checker.sv
// port-level checks for the mandelbrot escape-time block
// depends on mbe_pkg; bound to mandelbrot_escape_time below
module mbe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mbe_pkg::COUNT_W-1:0] escape_count,
  input logic                        stayed_inside
);

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a word and was not busy after it");

  // a result cannot appear the cycle after the word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too soon after the input word");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(escape_count)
      && $stable(stayed_inside))
    else $error("stalled result word changed");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

### test/tb_mandelbrot_escape_time.sv
// testbench for the mandelbrot escape-time counter: random and directed points
// checked against a fixed-point escape predictor; needs mbe_pkg and the top level
module tb_mandelbrot_escape_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 28;

  typedef logic signed [mbe_pkg::COORD_W-1:0] coord_t;
  typedef logic [mbe_pkg::COUNT_W-1:0]        count_t;

  // q4.28 landmarks
  localparam coord_t ONE   = 32'sd268435456;
  localparam coord_t C_MAX = 32'sh7fffffff;
  localparam coord_t C_MIN = 32'sh80000000;

  // expected result for one point
  typedef struct {
    coord_t re;
    coord_t im;
    count_t count;
    logic   in_set;
  } escape_t;

  class escape_scoreboard;
    escape_t pending_escapes[$];
    int unsigned iter_limit = mbe_pkg::MAX_ITER_RESET;
    int unsigned checked, errors, bounded, deepest;

    function int unsigned pending();
      return pending_escapes.size();
    endfunction

    // iterate z = z*z + c in fixed point, floor each new part before adding c
    function escape_t escape_time(coord_t re, coord_t im);
      logic signed [63:0]  cr, ci, zr, zi;
      logic signed [127:0] wr, wi, rr, ii, ri;
      logic [63:0]         ar, ai;
      logic [127:0]        radius2, bound;
      escape_t             res;
      int unsigned         k;
      cr = re;
      ci = im;
      zr = '0;
      zi = '0;
      bound = 128'd1 << (2 * FRAC + 2);
      res.re = re;
      res.im = im;
      res.count = count_t'(iter_limit);
      res.in_set = 1'b1;
      for (k = 0; k < iter_limit; k++) begin
        wr = zr;
        wi = zi;
        rr = wr * wr;
        ii = wi * wi;
        ri = wr * wi;
        rr = (rr - ii) >>> FRAC;
        ri = (ri + ri) >>> FRAC;
        zr = rr[63:0] + cr;
        zi = ri[63:0] + ci;
        // exact squared radius from magnitudes
        ar = zr[63] ? -zr : zr;
        ai = zi[63] ? -zi : zi;
        radius2 = {64'd0, ar} * {64'd0, ar} + {64'd0, ai} * {64'd0, ai};
        if (radius2 > bound) begin
          res.count = count_t'(k);
          res.in_set = 1'b0;
          break;
        end
      end
      return res;
    endfunction

    function void note_point(coord_t re, coord_t im);
      pending_escapes.push_back(escape_time(re, im));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(count_t count, logic stayed);
      escape_t want;
      if (pending_escapes.size() == 0) begin
        report($sformatf("result count %0d inside %b with no point pending", count, stayed));
        return;
      end
      want = pending_escapes.pop_front();
      checked++;
      if (count !== want.count)
        report($sformatf("c=(%h,%h) escape_count %0d, want %0d",
                         want.re, want.im, count, want.count));
      if (stayed !== want.in_set)
        report($sformatf("c=(%h,%h) stayed_inside %b, want %b",
                         want.re, want.im, stayed, want.in_set));
      if (want.in_set) bounded++;
      if (want.count > deepest) deepest = want.count;
    endtask
  endclass

  logic                      clk;
  logic                      rst            = 1'b1;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  coord_t                    c_re           = '0;
  coord_t                    c_im           = '0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  count_t                    escape_count;
  logic                      stayed_inside;
  logic                      cfg_write_en   = 1'b0;
  count_t                    cfg_write_data = '0;

  escape_scoreboard sb = new();
  bit               no_idle;
  bit               held_off;
  int unsigned      points_sent;
  int unsigned      limits_used;

  int unsigned phase_limit [7] = '{0, 1, 2, 8, 30, 100, 256};
  int unsigned phase_items [7] = '{30, 150, 150, 250, 300, 300, 240};

  mandelbrot_escape_time #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .c_re          (c_re),
    .c_im          (c_im),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .escape_count  (escape_count),
    .stayed_inside (stayed_inside),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word after a random gap unless no_idle is set, return at its acceptance edge
  task automatic send_point(input coord_t re, input coord_t im);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    c_re <= re;
    c_im <= im;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_point(re, im);
    points_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // new iteration limit, only while the block is idle
  task automatic write_limit(input int unsigned limit);
    cfg_write_en <= 1'b1;
    cfg_write_data <= count_t'(limit);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.iter_limit = limit;
    limits_used++;
  endtask

  function automatic coord_t edge_value();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return -1;
      4: return 2 * ONE;
      default: return -2 * ONE;
    endcase
  endfunction

  // mostly points near the set, some noise and extremes
  task automatic send_random_point();
    int     pick;
    coord_t re, im;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      re = -603979776 + int'($urandom_range(0, 805306368));
      im = -335544320 + int'($urandom_range(0, 671088640));
    end else if (pick < 75) begin
      re = -536870912 + int'($urandom_range(0, 603979776));
      im = -65536 + int'($urandom_range(0, 131072));
    end else if (pick < 90) begin
      re = $urandom();
      im = $urandom();
    end else begin
      re = edge_value();
      im = edge_value();
    end
    send_point(re, im);
  endtask

  // result side, with one long hold-off to back up the input
  initial begin : result_sink
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (!held_off && sb.checked == 100) begin
        hold = 600;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      sb.check_result(escape_count, stayed_inside);
    end
  end

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points at the reset limit
    send_point('0, '0);
    send_point(-2 * ONE, '0);
    send_point(-2 * ONE - 1, '0);
    send_point(2 * ONE, '0);
    send_point('0, 2 * ONE);
    send_point('0, -2 * ONE);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(C_MAX, C_MIN);
    send_point('0, C_MIN);
    send_point(C_MAX, '0);
    send_point(-1, -1);
    send_point(1, 1);
    send_point(ONE / 4, '0);
    send_point(-ONE, '0);
    send_point('0, ONE);
    send_point(-3 * ONE / 4, '0);
    send_point(-3 * ONE / 2, '0);
    send_point(ONE / 2, ONE / 2);
    send_point(-3 * ONE / 4, ONE / 10);
    send_point(3 * ONE / 10, '0);
    drain();

    // random phases over a spread of limits, zero among them
    for (int p = 0; p < 7; p++) begin
      no_idle = (p % 3 == 2);
      write_limit(phase_limit[p]);
      repeat (phase_items[p]) send_random_point();
      drain();
    end

    // widest limit: deep escapes and one bounded point
    no_idle = 1'b0;
    write_limit(65535);
    send_point('0, '0);
    send_point(ONE, '0);
    send_point(ONE / 4 + (1 << 12), '0);
    send_point(-3 * ONE / 4, ONE / 100);
    send_point(C_MAX, C_MIN);
    drain();
    repeat (50) @(posedge clk);

    $display("%0d points over %0d iteration limits, %0d results checked",
             points_sent, limits_used + 1, sb.checked);
    $display("%0d bounded, deepest count %0d, %0d mismatches",
             sb.bounded, sb.deepest, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### mandelbrot_escape_time.f
src/mbe_pkg.sv
src/mandelbrot_escape_time.sv
src/mbe_checker.sv
test/tb_mandelbrot_escape_time.sv
